FILE: src/lpht_pkg.sv
// Package for the linear-probing hash table: sizes, status and mode codes.
// Used by the core; depends on nothing.
`timescale 1ns / 1ps

package lpht_pkg;

  localparam int unsigned MAX_SLOTS  = 1024;
  localparam int unsigned SLOT_AW    = $clog2(MAX_SLOTS);
  localparam int unsigned SIZE_W     = SLOT_AW + 1;
  localparam int unsigned KEY_W      = 31;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned DIV_CNT_W  = $clog2(KEY_W);

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(1023);

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;

  localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_READ      = 3'd5;

endpackage

FILE: src/lpht_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/linear_probe_hash_table_core.sv
// Top level of the linear-probing hash table: sequencer, shared divider and probe logic.
// Depends on lpht_pkg and on the generic RAM lpht_ram.
`timescale 1ns / 1ps

// After reset the core clears the slot store and accepts no transfer meanwhile; configuration
// writes are taken at any time. A slot read goes from input transfer through the read, compare
// and done states to the result. An insert or find first reduces the key modulo the table size
// in a shared one-bit-per-cycle restoring divider, then probes one slot at a time, each through
// a read state and a compare state on the registered read port of the slot RAM; an insert
// refused as full on acceptance, or a zero key, skips the divider and goes straight to done. A
// finished result sits in the output register while the next input transfer is taken.
module linear_probe_hash_table_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lpht_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [lpht_pkg::MODE_W-1:0]          mode_i,
  input  logic [lpht_pkg::KEY_W-1:0]           key_i,
  input  logic [lpht_pkg::SLOT_AW-1:0]         slot_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [lpht_pkg::STATUS_W-1:0]        status_o,
  output logic signed [lpht_pkg::SIZE_W-1:0]   position_o,
  output logic [lpht_pkg::KEY_W-1:0]           slot_key_o
);

  localparam int unsigned AW = lpht_pkg::SLOT_AW;
  localparam int unsigned SW = lpht_pkg::SIZE_W;
  localparam int unsigned KW = lpht_pkg::KEY_W;
  localparam int unsigned CW = lpht_pkg::DIV_CNT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [SW-1:0]               table_size_q;
  logic [SW-1:0]               count_q, count_d;
  logic [AW-1:0]               clr_q, clr_d;
  logic [SW-1:0]               m_q, m_d, m_eff;
  logic [lpht_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [KW-1:0]               key_q, key_d;
  logic [SW-1:0]               rem_q, rem_d;
  logic [CW-1:0]               div_cnt_q, div_cnt_d;
  logic [AW-1:0]               idx_q, idx_d;
  logic [AW-1:0]               left_q, left_d;
  logic [lpht_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic [SW-1:0]               res_pos_q, res_pos_d;
  logic [KW-1:0]               res_skey_q, res_skey_d;
  logic                        out_valid_q, out_valid_d;
  logic [lpht_pkg::STATUS_W-1:0] status_q, status_d;
  logic [SW-1:0]               position_q, position_d;
  logic [KW-1:0]               slot_key_q, slot_key_d;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [KW-1:0]               ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [KW-1:0]               ram_rdata;

  logic [SW:0]                 trial;
  logic [SW-1:0]               idx_inc;
  logic                        in_fire;

  lpht_ram #(
    .WIDTH (KW),
    .DEPTH (lpht_pkg::MAX_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (table_size_q == '0) begin
      m_eff = SW'(1);
    end else if (table_size_q > SW'(lpht_pkg::MAX_SLOTS)) begin
      m_eff = SW'(lpht_pkg::MAX_SLOTS);
    end else begin
      m_eff = table_size_q;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign trial      = {rem_q, key_q[div_cnt_q]};
  assign idx_inc    = {1'b0, idx_q} + SW'(1);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    clr_d        = clr_q;
    m_d          = m_q;
    mode_d       = mode_q;
    key_d        = key_q;
    rem_d        = rem_q;
    div_cnt_d    = div_cnt_q;
    idx_d        = idx_q;
    left_d       = left_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_skey_d   = res_skey_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    position_d   = position_q;
    slot_key_d   = slot_key_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = key_q;
    ram_raddr    = idx_q;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          mode_d     = mode_i;
          key_d      = key_i;
          m_d        = m_eff;
          idx_d      = slot_i;
          rem_d      = '0;
          div_cnt_d  = CW'(KW - 1);
          res_pos_d  = '1;
          res_skey_d = '0;
          case (mode_i)
            lpht_pkg::MODE_INSERT: begin
              if (count_q >= m_eff - SW'(1)) begin
                res_status_d = lpht_pkg::STATUS_FULL;
                state_d      = S_DONE;
              end else if (key_i == '0) begin
                res_status_d = lpht_pkg::STATUS_DUPLICATE;
                state_d      = S_DONE;
              end else begin
                state_d = S_DIV;
              end
            end
            lpht_pkg::MODE_FIND: begin
              if (key_i == '0) begin
                res_status_d = lpht_pkg::STATUS_NOT_FOUND;
                state_d      = S_DONE;
              end else begin
                state_d = S_DIV;
              end
            end
            default: begin
              res_status_d = lpht_pkg::STATUS_READ;
              state_d      = S_RD;
            end
          endcase
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, m_q}) begin
          rem_d = SW'(trial - {1'b0, m_q});
        end else begin
          rem_d = trial[SW-1:0];
        end
        div_cnt_d = div_cnt_q - CW'(1);
        if (div_cnt_q == '0) begin
          idx_d   = rem_d[AW-1:0];
          left_d  = AW'(m_q - SW'(1));
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_DONE;
        case (mode_q)
          lpht_pkg::MODE_INSERT: begin
            if (ram_rdata == key_q) begin
              res_status_d = lpht_pkg::STATUS_DUPLICATE;
            end else if (ram_rdata == '0) begin
              ram_we       = 1'b1;
              count_d      = count_q + SW'(1);
              res_status_d = lpht_pkg::STATUS_INSERTED;
              res_pos_d    = {1'b0, idx_q};
            end else if (left_q == '0) begin
              res_status_d = lpht_pkg::STATUS_FULL;
            end else begin
              state_d = S_RD;
            end
          end
          lpht_pkg::MODE_FIND: begin
            if (ram_rdata == key_q) begin
              res_status_d = lpht_pkg::STATUS_FOUND;
              res_pos_d    = {1'b0, idx_q};
            end else if (ram_rdata == '0 || left_q == '0) begin
              res_status_d = lpht_pkg::STATUS_NOT_FOUND;
            end else begin
              state_d = S_RD;
            end
          end
          default: begin
            res_skey_d = ram_rdata;
          end
        endcase
        if (state_d == S_RD) begin
          left_d = left_q - AW'(1);
          idx_d  = (idx_inc == m_q) ? '0 : idx_inc[AW-1:0];
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          position_d  = res_pos_q;
          slot_key_d  = res_skey_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      count_q      <= '0;
      table_size_q <= lpht_pkg::TABLE_SIZE_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        table_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_q          <= m_d;
    mode_q       <= mode_d;
    key_q        <= key_d;
    rem_q        <= rem_d;
    div_cnt_q    <= div_cnt_d;
    idx_q        <= idx_d;
    left_q       <= left_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_skey_q   <= res_skey_d;
    status_q     <= status_d;
    position_q   <= position_d;
    slot_key_q   <= slot_key_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign position_o  = $signed(position_q);
  assign slot_key_o  = slot_key_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < SW'(lpht_pkg::MAX_SLOTS))
    else $error("Occupied count has reached the number of slots.");

  a_no_zero_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != S_CLEAR) |-> ram_wdata != '0)
    else $error("An insert wrote an empty key into the slot store.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != S_CLEAR) |=> count_q == $past(count_q) + SW'(1))
    else $error("Occupied count did not follow an insert.");

  a_pos_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == lpht_pkg::STATUS_INSERTED ||
                     status_o == lpht_pkg::STATUS_FOUND)) |-> !position_o[SW-1])
    else $error("A successful transfer carries a negative position.");

endmodule

FILE: tb/lpht_checker.sv
// Result checker for the linear-probing hash table core: watches both channels,
// keeps its own copy of the slot store and table size, and compares every result.
// Depends on lpht_pkg.
`timescale 1ns / 1ps

module lpht_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lpht_pkg::SIZE_W-1:0]        cfg_wdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [lpht_pkg::MODE_W-1:0]        mode_i,
  input  logic [lpht_pkg::KEY_W-1:0]         key_i,
  input  logic [lpht_pkg::SLOT_AW-1:0]       slot_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [lpht_pkg::STATUS_W-1:0]      status_i,
  input  logic signed [lpht_pkg::SIZE_W-1:0] position_i,
  input  logic [lpht_pkg::KEY_W-1:0]         slot_key_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 compared_o,
  output int                                 stored_o,
  output int                                 found_o
);
  import lpht_pkg::*;

  localparam logic signed [SIZE_W-1:0] NO_POSITION = '1;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [SIZE_W-1:0] position;
    logic [KEY_W-1:0]         slot_key;
  } table_reply_t;

  logic [KEY_W-1:0]  slot_store [MAX_SLOTS];
  int unsigned       keys_held;
  logic [SIZE_W-1:0] size_reg;
  table_reply_t      reply_fifo [$];

  function automatic int unsigned usable_slots();
    int unsigned m;
    m = size_reg;
    if (m == 0) m = 1;
    if (m > MAX_SLOTS) m = MAX_SLOTS;
    return m;
  endfunction

  // Gives the slot holding the key, or -1 once an empty slot or the probe limit is met.
  function automatic int probe_for(logic [KEY_W-1:0] k, int unsigned m);
    int unsigned left;
    int unsigned idx;
    left = m - 1;
    idx = k % m;
    while (left != 0 && slot_store[idx] != k && slot_store[idx] != '0) begin
      idx++;
      left--;
      if (idx >= m) idx -= m;
    end
    if (slot_store[idx] == k) return int'(idx);
    return -1;
  endfunction

  function automatic table_reply_t predict_reply(logic [MODE_W-1:0] op, logic [KEY_W-1:0] k,
                                                 logic [SLOT_AW-1:0] s);
    table_reply_t r;
    int unsigned  m;
    int unsigned  idx;
    int unsigned  tries;
    int           hit;
    m = usable_slots();
    r.status = STATUS_READ;
    r.position = NO_POSITION;
    r.slot_key = '0;
    if (op == MODE_INSERT) begin
      if (keys_held >= m - 1) begin
        r.status = STATUS_FULL;
      end else if (k == '0 || probe_for(k, m) >= 0) begin
        r.status = STATUS_DUPLICATE;
      end else begin
        idx = k % m;
        tries = 0;
        while (tries < m && slot_store[idx] != '0) begin
          idx++;
          tries++;
          if (idx >= m) idx -= m;
        end
        if (tries >= m) begin
          r.status = STATUS_FULL;
        end else begin
          slot_store[idx] = k;
          keys_held++;
          r.status = STATUS_INSERTED;
          r.position = SIZE_W'(idx);
        end
      end
    end else if (op == MODE_FIND) begin
      hit = (k == '0) ? -1 : probe_for(k, m);
      if (hit >= 0) begin
        r.status = STATUS_FOUND;
        r.position = SIZE_W'(hit);
      end else begin
        r.status = STATUS_NOT_FOUND;
      end
    end else begin
      r.slot_key = slot_store[s];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_reply_t seen;
    table_reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SLOTS; i++) slot_store[i] = '0;
      keys_held = 0;
      size_reg = TABLE_SIZE_RST;
      reply_fifo.delete();
      fail_count_o = 0;
      compared_o = 0;
      stored_o = 0;
      found_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen.status = status_i;
        seen.position = position_i;
        seen.slot_key = slot_key_i;
        if (reply_fifo.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT)
            $display("%0t: unexpected result: status %0d position %0d key %h",
                     $time, seen.status, seen.position, seen.slot_key);
        end else begin
          want = reply_fifo.pop_front();
          compared_o++;
          if (want !== seen) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT) begin
              $display("%0t: wrong result: expected status %0d position %0d key %h,",
                       $time, want.status, want.position, want.slot_key);
              $display("  got status %0d position %0d key %h",
                       seen.status, seen.position, seen.slot_key);
            end
          end else if (want.status == STATUS_INSERTED) begin
            stored_o++;
          end else if (want.status == STATUS_FOUND) begin
            found_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) reply_fifo = {reply_fifo, predict_reply(mode_i, key_i, slot_i)};
      if (cfg_we_i) size_reg = cfg_wdata_i;
      pending_o = reply_fifo.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the hash table testbench: clock, reset, stimulus and verdict.
// Drives linear_probe_hash_table_core and checks it through lpht_checker; uses lpht_pkg.
`timescale 1ns / 1ps

module testbench;
  import lpht_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SLOT_READ = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE     = 2'd3;
  localparam int CYCLE_LIMIT     = 20_000_000;
  localparam int DRAIN_CYCLES    = 2200;
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 92;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [SIZE_W-1:0]          cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [MODE_W-1:0]          mode_i;
  logic [KEY_W-1:0]           key_i;
  logic [SLOT_AW-1:0]         slot_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [STATUS_W-1:0]        status_o;
  logic signed [SIZE_W-1:0]   position_o;
  logic [KEY_W-1:0]           slot_key_o;

  int fail_count;
  int pending;
  int compared;
  int stored;
  int found;
  int cycles = 0;
  int items_sent = 0;
  int sizes_used = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  logic [KEY_W-1:0]  known_keys [$];
  logic [SIZE_W-1:0] phase_sizes [PHASES];

  linear_probe_hash_table_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .key_i       (key_i),
    .slot_i      (slot_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .position_o  (position_o),
    .slot_key_o  (slot_key_o)
  );

  lpht_checker table_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .slot_i       (slot_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status_o),
    .position_i   (position_o),
    .slot_key_i   (slot_key_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .compared_o   (compared),
    .stored_o     (stored),
    .found_o      (found)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("linear_probe_hash_table_core: mismatch");
      $finish;
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic apply_op(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k,
                          input logic [SLOT_AW-1:0] s);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= op;
    key_i <= k;
    slot_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic set_table_size(input logic [SIZE_W-1:0] size);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= size;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sizes_used++;
  endtask

  // Known keys, clustered keys sharing a few home slots, or fully random keys.
  function automatic logic [KEY_W-1:0] pick_key(int unsigned m);
    int unsigned c;
    int unsigned home;
    c = $urandom_range(0, 99);
    if (c < 35 && known_keys.size() != 0)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    if (c < 70) begin
      home = (m < 8) ? $urandom_range(0, m - 1) : $urandom_range(0, 7);
      return KEY_W'(home + m * $urandom_range(1, 2000000));
    end
    return KEY_W'($urandom);
  endfunction

  task automatic random_op(input int unsigned m);
    int unsigned      r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      k = pick_key(m);
      if (k != '0) known_keys = {known_keys, k};
      apply_op(MODE_INSERT, k, SLOT_AW'($urandom));
    end else if (r < 72) begin
      apply_op(MODE_FIND, pick_key(m), SLOT_AW'($urandom));
    end else if (r < 92) begin
      apply_op(MODE_SLOT_READ, KEY_W'($urandom),
               $urandom_range(0, 1) ? SLOT_AW'($urandom_range(0, m - 1)) : SLOT_AW'($urandom));
    end else if (r < 96) begin
      apply_op(MODE_SPARE, KEY_W'($urandom), SLOT_AW'($urandom));
    end else begin
      apply_op($urandom_range(0, 1) ? MODE_FIND : MODE_INSERT, '0, SLOT_AW'($urandom));
    end
  endtask

  initial begin
    int unsigned m;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = MODE_INSERT;
    key_i = '0;
    slot_i = '0;
    phase_sizes = '{11'd16, 11'd37, 11'd3, 11'd100, 11'd128, 11'd9, 11'd255, 11'd511,
                    11'd1024, 11'd0, 11'd700, 11'd2047, 11'd1000, 11'd1023};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table at the reset size: zero keys and reads of empty slots.
    apply_op(MODE_SLOT_READ, '0, '0);
    apply_op(MODE_SLOT_READ, '0, '1);
    apply_op(MODE_FIND, 31'd5, '0);
    apply_op(MODE_INSERT, '0, '0);
    apply_op(MODE_FIND, '0, '0);

    // A one-slot table is always full; a size of zero behaves the same.
    set_table_size(11'd1);
    apply_op(MODE_INSERT, 31'd7, '0);
    apply_op(MODE_FIND, 31'd7, '0);
    apply_op(MODE_SPARE, '0, '0);
    set_table_size(11'd0);
    apply_op(MODE_INSERT, 31'd9, '0);

    // Four slots: collision, wrap at the end, duplicate, then refusal when full.
    set_table_size(11'd4);
    apply_op(MODE_INSERT, 31'd3, '0);
    apply_op(MODE_INSERT, 31'd7, '0);
    apply_op(MODE_INSERT, 31'd7, '0);
    apply_op(MODE_INSERT, 31'd11, '0);
    apply_op(MODE_INSERT, 31'd2, '0);
    apply_op(MODE_FIND, 31'd11, '0);
    apply_op(MODE_FIND, 31'd15, '0);
    apply_op(MODE_SLOT_READ, '0, 10'd1);

    // An oversized setting is clipped to the full store; largest key in the last slot.
    set_table_size('1);
    apply_op(MODE_INSERT, '1, '0);
    apply_op(MODE_INSERT, 31'd1024, '0);
    apply_op(MODE_FIND, '1, '0);
    apply_op(MODE_SLOT_READ, '0, '1);
    known_keys = '{31'd3, 31'd7, 31'd11, 31'd1024, 31'h7fff_ffff};

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
        default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
      endcase
      set_table_size(phase_sizes[p]);
      m = phase_sizes[p];
      if (m == 0) m = 1;
      if (m > MAX_SLOTS) m = MAX_SLOTS;
      repeat (ITEMS_PER_PHASE) random_op(m);
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("%0d operations sent across %0d table size settings, %0d results compared.",
             items_sent, sizes_used, compared);
    $display("%0d keys were stored and %0d lookups found their key.", stored, found);
    if (fail_count == 0 && pending == 0) begin
      $display("linear_probe_hash_table_core: match");
    end else begin
      $display("linear_probe_hash_table_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
src/lpht_pkg.sv
src/lpht_ram.sv
src/linear_probe_hash_table_core.sv
tb/lpht_checker.sv
tb/testbench.sv
